>>> rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// shared widths, status codes and message type for the midi byte parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

  localparam int BYTE_W = 8;
  localparam int DATA_W = 7;
  localparam int LEN_W  = 2;
  localparam int CHAN_W = 5;
  localparam int NIB_W  = 4;
  localparam int PFX_W  = 6;

  localparam logic [BYTE_W-1:0] STATUS_NONE   = 8'h00;
  localparam logic [BYTE_W-1:0] SYSEX_START   = 8'hF0;
  localparam logic [BYTE_W-1:0] TIME_CODE     = 8'hF1;
  localparam logic [BYTE_W-1:0] SONG_POSITION = 8'hF2;
  localparam logic [BYTE_W-1:0] SONG_SELECT   = 8'hF3;
  localparam logic [BYTE_W-1:0] SYSEX_END     = 8'hF7;
  localparam logic [BYTE_W-1:0] REALTIME_MIN  = 8'hF8;

  // f4 to f7 share this upper six-bit prefix
  localparam logic [PFX_W-1:0] SYS_ONE_BYTE_PFX = 6'h3D;

  localparam logic [NIB_W-1:0] NIB_NOTE_OFF   = 4'h8;
  localparam logic [NIB_W-1:0] NIB_NOTE_ON    = 4'h9;
  localparam logic [NIB_W-1:0] NIB_POLY_PRESS = 4'hA;
  localparam logic [NIB_W-1:0] NIB_CTRL_CHG   = 4'hB;
  localparam logic [NIB_W-1:0] NIB_PROG_CHG   = 4'hC;
  localparam logic [NIB_W-1:0] NIB_CHAN_PRESS = 4'hD;
  localparam logic [NIB_W-1:0] NIB_PITCH_BEND = 4'hE;

  localparam logic [LEN_W-1:0] LEN_ONE   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  localparam logic [CHAN_W-1:0] CHAN_OMNI = 5'd0;
  localparam logic [CHAN_W-1:0] CHAN_ONE  = 5'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [DATA_W-1:0] data1;
    logic [DATA_W-1:0] data2;
    logic [LEN_W-1:0]  length;
  } msg_t;

endpackage

`default_nettype wire

>>> rtl/midi_byte_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// parses a midi byte stream into complete messages with running status
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-----------------------------------
//  in        | in_valid / in_stall           | rx_byte
//  out       | out_valid / out_stall         | msg_status msg_data1 msg_data2
//            |                               | msg_length
//  cfg       | channel_select_we             | channel_select
//
//  one byte per cycle unless stalled; a message is registered after its last byte
//  the decision for each byte is one pass of logic into the output register
//  in_stall is high during reset and while the output register is held
//  reset clears running status, the partial message, sysex state and the filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbsp_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbsp_pkg::BYTE_W-1:0]   msg_status,
  output logic [mbsp_pkg::DATA_W-1:0]   msg_data1,
  output logic [mbsp_pkg::DATA_W-1:0]   msg_data2,
  output logic [mbsp_pkg::LEN_W-1:0]    msg_length,
  input  logic                          channel_select_we,
  input  logic [mbsp_pkg::CHAN_W-1:0]   channel_select
);
  import mbsp_pkg::*;

  logic [CHAN_W-1:0] chan_sel;
  logic [BYTE_W-1:0] cur_status;
  logic [BYTE_W-1:0] cur_status_next;
  logic [BYTE_W-1:0] pending_status;
  logic [BYTE_W-1:0] pending_status_next;
  logic [DATA_W-1:0] pending_first_data;
  logic [DATA_W-1:0] pending_first_data_next;
  logic              awaiting_second_data;
  logic              awaiting_second_data_next;
  logic              sysex_draining;
  logic              sysex_draining_next;
  msg_t              msg;
  msg_t              msg_next;
  logic              emit;
  logic              accept;
  logic              is_voice;
  logic              chan_pass;

  assign in_stall = rst | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  assign is_voice  = cur_status[BYTE_W-1] && (cur_status < SYSEX_START);
  assign chan_pass = !(is_voice && (chan_sel != CHAN_OMNI) &&
                       ({1'b0, cur_status[NIB_W-1:0]} != (chan_sel - CHAN_ONE)));

  always_comb begin
    cur_status_next           = cur_status;
    pending_status_next       = pending_status;
    pending_first_data_next   = pending_first_data;
    awaiting_second_data_next = awaiting_second_data;
    sysex_draining_next       = sysex_draining;
    emit                      = 1'b0;
    msg_next                  = '0;
    if (accept) begin
      if (rx_byte >= REALTIME_MIN) begin
        emit            = 1'b1;
        msg_next.status = rx_byte;
        msg_next.length = LEN_ONE;
      end else if (sysex_draining) begin
        if (rx_byte == SYSEX_END) begin
          sysex_draining_next = 1'b0;
        end
      end else if (rx_byte[BYTE_W-1]) begin
        awaiting_second_data_next = 1'b0;
        if (rx_byte == SYSEX_START) begin
          sysex_draining_next = 1'b1;
          cur_status_next     = STATUS_NONE;
        end else if (rx_byte[BYTE_W-1 -: PFX_W] == SYS_ONE_BYTE_PFX) begin
          cur_status_next = STATUS_NONE;
          emit            = 1'b1;
          msg_next.status = rx_byte;
          msg_next.length = LEN_ONE;
        end else begin
          cur_status_next = rx_byte;
        end
      end else if (!chan_pass) begin
        // filtered channel, byte dropped
        emit = 1'b0;
      end else if (awaiting_second_data) begin
        awaiting_second_data_next = 1'b0;
        emit                      = 1'b1;
        msg_next.status           = pending_status;
        msg_next.data1            = pending_first_data;
        msg_next.data2            = rx_byte[DATA_W-1:0];
        msg_next.length           = LEN_THREE;
      end else if (cur_status == STATUS_NONE) begin
        // no status to apply, byte dropped
        emit = 1'b0;
      end else if (cur_status < SYSEX_START) begin
        case (cur_status[BYTE_W-1 -: NIB_W])
          NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL_CHG, NIB_PITCH_BEND: begin
            pending_status_next       = cur_status;
            pending_first_data_next   = rx_byte[DATA_W-1:0];
            awaiting_second_data_next = 1'b1;
          end
          NIB_PROG_CHG, NIB_CHAN_PRESS: begin
            emit            = 1'b1;
            msg_next.status = cur_status;
            msg_next.data1  = rx_byte[DATA_W-1:0];
            msg_next.length = LEN_TWO;
          end
          default: begin
            cur_status_next = STATUS_NONE;
          end
        endcase
      end else begin
        cur_status_next = STATUS_NONE;
        if (cur_status == SONG_POSITION) begin
          pending_status_next       = cur_status;
          pending_first_data_next   = rx_byte[DATA_W-1:0];
          awaiting_second_data_next = 1'b1;
        end else if (cur_status == TIME_CODE || cur_status == SONG_SELECT) begin
          emit            = 1'b1;
          msg_next.status = cur_status;
          msg_next.data1  = rx_byte[DATA_W-1:0];
          msg_next.length = LEN_TWO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_sel             <= CHAN_OMNI;
      cur_status           <= STATUS_NONE;
      pending_status       <= STATUS_NONE;
      pending_first_data   <= '0;
      awaiting_second_data <= 1'b0;
      sysex_draining       <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (channel_select_we) begin
        chan_sel <= channel_select;
      end
      cur_status           <= cur_status_next;
      pending_status       <= pending_status_next;
      pending_first_data   <= pending_first_data_next;
      awaiting_second_data <= awaiting_second_data_next;
      sysex_draining       <= sysex_draining_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      msg <= msg_next;
    end
  end

  assign msg_status = msg.status;
  assign msg_data1  = msg.data1;
  assign msg_data2  = msg.data2;
  assign msg_length = msg.length;

  // real-time bytes come out on the next cycle unchanged
  a_realtime_pass: assert property (@(posedge clk) disable iff (rst)
    (accept && rx_byte >= REALTIME_MIN) |=>
      (out_valid && msg_status == $past(rx_byte) && msg_length == LEN_ONE))
    else $error("real-time byte not passed through");

  // sysex always leaves running status cleared
  a_sysex_clears_rs: assert property (@(posedge clk) disable iff (rst)
    sysex_draining |-> (cur_status == STATUS_NONE))
    else $error("running status set while draining sysex");

  // a partial message always carries a status byte
  a_pending_status: assert property (@(posedge clk) disable iff (rst)
    awaiting_second_data |-> pending_status[BYTE_W-1])
    else $error("awaiting second data without status");

  // one-byte messages are f4 and above with no data
  a_one_byte_msg: assert property (@(posedge clk) disable iff (rst)
    (out_valid && msg_length == LEN_ONE) |->
      (msg_status[BYTE_W-1 -: PFX_W] >= SYS_ONE_BYTE_PFX && msg_data1 == '0 &&
       msg_data2 == '0))
    else $error("bad one-byte message");

  // every emitted message has a status byte and a nonzero length
  a_msg_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (msg_status[BYTE_W-1] && msg_length != '0))
    else $error("malformed message");

endmodule

`default_nettype wire
